/* rtl/dmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_pkg: shared definitions for the maximum-flow engine
// Default sizes, request and status codes, and the arc-store control bundle.
// ----------------------------------------------------------------------------
package dmf_pkg;

    // default sizes
    localparam int DEF_MAX_NODES = 256;
    localparam int DEF_MAX_ARCS  = 2048;
    localparam int DEF_CAP_BITS  = 32;

    // fixed port widths
    localparam int CFG_W     = 9;
    localparam int KIND_W    = 2;
    localparam int IN_NODE_W = 8;
    localparam int IN_CAP_W  = 32;
    localparam int OUT_W     = 42;
    localparam int STAT_W    = 2;

    // width of the need and got values of a search frame
    localparam int NEED_W = 61;
    localparam logic [NEED_W-1:0] NEED_TOP = {1'b1, {(NEED_W-1){1'b0}}};
    localparam logic [OUT_W-1:0]  OUT_MAX  = '1;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // write enables toward the arc store
    typedef struct packed {
        logic wr_arc;   // target and next of one arc
        logic wr_cap;   // capacity of one arc pair
        logic wr_flow;  // flow of one arc pair
    } t_arc_ctl;

endpackage

/* rtl/dinic_max_flow_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dinic_max_flow_engine: maximum flow by Dinic's method
// Stores a directed graph as linked arc lists and answers each request with
// one result: clear, add edge, or the maximum flow from a source to a sink.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Clear, unknown
// kinds and rejected requests answer on the next cycle without raising busy.
// An add keeps busy high through the states S_ADD0 to S_ADD3 and answers
// after the last of them. A compute first zeroes the flows, then per phase
// labels the levels of the reached nodes along their arcs and runs the
// blocking-flow search, which tries arcs and pushes and pops search frames.
// Each result shows for one cycle with o_valid; the receiver cannot stall it.
// The node count register takes a write only while busy is low.
module dinic_max_flow_engine #(
    parameter int MAX_NODES = dmf_pkg::DEF_MAX_NODES,
    parameter int MAX_ARCS  = dmf_pkg::DEF_MAX_ARCS,
    parameter int CAP_BITS  = dmf_pkg::DEF_CAP_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dmf_pkg::KIND_W-1:0]     i_kind,
    input  logic [dmf_pkg::IN_NODE_W-1:0]  i_node_a,
    input  logic [dmf_pkg::IN_NODE_W-1:0]  i_node_b,
    input  logic [dmf_pkg::IN_CAP_W-1:0]   i_capacity,
    output logic                           o_valid,
    output logic [dmf_pkg::OUT_W-1:0]      o_total_flow,
    output logic [dmf_pkg::STAT_W-1:0]     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dmf_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int SPW = $clog2(MAX_NODES + 1);
    localparam int AW  = $clog2(MAX_ARCS + 1);
    localparam int XW  = $clog2(MAX_ARCS);
    localparam int PW  = (MAX_ARCS > 2) ? $clog2((MAX_ARCS + 1) / 2) : 1;
    localparam int EW  = dmf_pkg::NEED_W + 1;
    localparam int QW  = 2 * NW;
    localparam int SW  = 2 * NW + 2 * AW + 2 * dmf_pkg::NEED_W;
    localparam int RST_NC = (MAX_NODES < 256) ? MAX_NODES : 256;
    localparam logic [AW-1:0] NO_ARC = AW'(MAX_ARCS);

    typedef enum logic [4:0] {
        S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3, S_CLR, S_LVL_INIT,
        S_BFS_POP, S_BFS_HEAD, S_BFS_HEADW, S_BFS_ARC, S_BFS_EVAL,
        S_DFS_INIT, S_DFS_HEAD, S_DFS_STEP, S_DFS_ARC, S_DFS_LVL,
        S_DFS_POP1, S_DFS_POP2, S_PHASE_END
    } t_state;

    t_state r_state;

    // request fields and configuration
    logic [dmf_pkg::IN_NODE_W-1:0] r_a, r_b;
    logic [dmf_pkg::IN_CAP_W-1:0]  r_cap;
    logic [dmf_pkg::CFG_W-1:0]     r_node_count;

    // graph bookkeeping
    logic [AW-1:0]        r_arc_cnt;
    logic [MAX_NODES-1:0] r_head_ok;
    logic [MAX_NODES-1:0] r_lvl_ok;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_arc;

    // labelling queue pointers
    logic [SPW-1:0] r_rd, r_wr;
    logic [NW-1:0]  r_x_lv;

    // current search frame
    logic [SPW-1:0]                r_sp;
    logic [NW-1:0]                 r_fn, r_flv;
    logic [AW-1:0]                 r_fa, r_fin, r_cur;
    logic [dmf_pkg::NEED_W-1:0]    r_fneed, r_fgot, r_left, r_res;
    logic [NW-1:0]                 r_y;
    logic [CAP_BITS-1:0]           r_room;
    logic [dmf_pkg::OUT_W-1:0]     r_total;

    // result register
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [dmf_pkg::OUT_W-1:0]     r_out_flow;
    logic [dmf_pkg::STAT_W-1:0]    r_out_status;

    // memories
    logic [AW-1:0] r_head_mem [MAX_NODES];
    logic [NW-1:0] r_lvl_mem  [MAX_NODES];
    logic [QW-1:0] r_q_mem    [MAX_NODES];
    logic [SW-1:0] r_stk_mem  [MAX_NODES];
    logic [AW-1:0] r_head_rd;
    logic          r_head_rd_ok;
    logic [NW-1:0] r_lvl_rd;
    logic [QW-1:0] r_q_rd;
    logic [SW-1:0] r_stk_rd;

    // memory ports and arc store hookup
    dmf_pkg::t_arc_ctl   arc_ctl;
    logic [XW-1:0]       arc_addr;
    logic [PW-1:0]       pair_addr;
    logic                arc_odd;
    logic [NW-1:0]       arc_wt;
    logic [AW-1:0]       arc_wn;
    logic [CAP_BITS-1:0] arc_wflow;
    logic [NW-1:0]       arc_target;
    logic [AW-1:0]       arc_next;
    logic [CAP_BITS-1:0] arc_room;
    logic [CAP_BITS-1:0] arc_flow;

    logic          head_we;
    logic [NW-1:0] head_wa, head_ra;
    logic [AW-1:0] head_wd;
    logic          lvl_we;
    logic [NW-1:0] lvl_wa, lvl_wd, lvl_ra;
    logic          q_we;
    logic [NW-1:0] q_wa, q_ra;
    logic [QW-1:0] q_wd;
    logic          stk_we;
    logic [NW-1:0] stk_wa, stk_ra;

    // shared adder
    logic [EW-1:0] alu_a, alu_b, alu_y;
    logic          alu_sub;

    logic [NW-1:0] node_a, node_b;
    logic [AW-1:0] head_next;
    logic          bfs_label, dfs_push, dfs_hit, dfs_adv;
    logic [dmf_pkg::NEED_W-1:0] room_ext;

    // request decode
    logic                       in_range, add_room, add_go, cmp_go;
    logic [dmf_pkg::STAT_W-1:0] in_status;

    assign node_a    = NW'(r_a);
    assign node_b    = NW'(r_b);
    assign head_next = r_head_rd_ok ? r_head_rd : NO_ARC;
    assign alu_y     = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign room_ext  = dmf_pkg::NEED_W'(r_room);

    assign in_range  = (i_node_a < r_node_count) && (i_node_b < r_node_count);
    assign add_room  = (32'(r_arc_cnt) + 32'd2 <= MAX_ARCS);
    assign add_go    = (i_kind == dmf_pkg::KIND_ADD) && in_range && add_room;
    assign cmp_go    = (i_kind == dmf_pkg::KIND_COMPUTE) && in_range
                       && (i_node_a != i_node_b);
    assign in_status = (((i_kind == dmf_pkg::KIND_ADD) ||
                         (i_kind == dmf_pkg::KIND_COMPUTE)) && !in_range)
                       ? dmf_pkg::STAT_RANGE
                       : (((i_kind == dmf_pkg::KIND_ADD) && !add_room)
                          ? dmf_pkg::STAT_FULL : dmf_pkg::STAT_OK);

    assign bfs_label = (arc_target < r_node_count) && !r_lvl_ok[arc_target]
                       && (arc_room != '0);
    assign dfs_push  = (r_y < r_node_count) && r_lvl_ok[r_y]
                       && ({1'b0, r_lvl_rd} == ({1'b0, r_flv} + 1'b1))
                       && (r_room != '0) && (32'(r_sp) < MAX_NODES);
    assign dfs_hit   = (r_fn == node_b);
    assign dfs_adv   = (r_fgot < r_fneed) && (r_fa != NO_ARC);

    // raise the result strobe on every answering step
    always_comb begin
        case (r_state)
            S_IDLE:    n_out_valid = start && !add_go && !cmp_go;
            S_ADD3:    n_out_valid = 1'b1;
            S_BFS_POP: n_out_valid = (r_rd == r_wr) && !r_lvl_ok[node_b];
            default:   n_out_valid = 1'b0;
        endcase
    end

    // steer memory ports and the adder by state
    always_comb begin
        arc_ctl   = '0;
        arc_addr  = XW'(r_arc);
        pair_addr = PW'(r_arc >> 1);
        arc_odd   = r_arc[0];
        arc_wt    = node_b;
        arc_wn    = head_next;
        arc_wflow = '0;
        head_we   = 1'b0;
        head_wa   = node_a;
        head_wd   = r_arc_cnt;
        head_ra   = node_a;
        lvl_we    = 1'b0;
        lvl_wa    = arc_target;
        lvl_wd    = NW'({1'b0, r_x_lv} + 1'b1);
        lvl_ra    = arc_target;
        q_we      = 1'b0;
        q_wa      = r_wr[NW-1:0];
        q_wd      = {NW'({1'b0, r_x_lv} + 1'b1), arc_target};
        q_ra      = r_rd[NW-1:0];
        stk_we    = 1'b0;
        stk_wa    = r_sp[NW-1:0];
        stk_ra    = NW'(r_sp - 1'b1);
        alu_a     = EW'(r_fneed);
        alu_b     = EW'(r_fgot);
        alu_sub   = 1'b1;
        case (r_state)
            S_ADD1: begin
                arc_ctl.wr_arc = 1'b1;
                arc_ctl.wr_cap = 1'b1;
                arc_addr       = XW'(r_arc_cnt);
                pair_addr      = PW'(r_arc_cnt >> 1);
                head_we        = 1'b1;
            end
            S_ADD2: begin
                head_ra = node_b;
            end
            S_ADD3: begin
                arc_ctl.wr_arc = 1'b1;
                arc_addr       = XW'(r_arc_cnt + 1'b1);
                arc_wt         = node_a;
                head_we        = 1'b1;
                head_wa        = node_b;
                head_wd        = r_arc_cnt + 1'b1;
            end
            S_CLR: begin
                arc_ctl.wr_flow = (r_idx != (r_arc_cnt >> 1));
                pair_addr       = PW'(r_idx);
            end
            S_LVL_INIT: begin
                lvl_we = 1'b1;
                lvl_wa = node_a;
                lvl_wd = '0;
                q_we   = 1'b1;
                q_wa   = '0;
                q_wd   = {{NW{1'b0}}, node_a};
            end
            S_BFS_HEAD: begin
                head_ra = r_q_rd[NW-1:0];
            end
            S_BFS_EVAL: begin
                lvl_we = bfs_label;
                q_we   = bfs_label && (32'(r_wr) < MAX_NODES);
            end
            S_DFS_STEP: begin
                if (!dfs_hit && dfs_adv) begin
                    arc_addr  = XW'(r_fa);
                    pair_addr = PW'(r_fa >> 1);
                    arc_odd   = r_fa[0];
                end else begin
                    pair_addr = PW'(r_fin >> 1);
                end
            end
            S_DFS_LVL: begin
                stk_we  = dfs_push;
                head_ra = r_y;
            end
            S_DFS_POP1: begin
                arc_ctl.wr_flow = 1'b1;
                pair_addr       = PW'(r_fin >> 1);
                alu_a           = EW'(arc_flow);
                alu_b           = EW'(r_res);
                alu_sub         = r_fin[0];
                arc_wflow       = CAP_BITS'(alu_y);
            end
            S_DFS_POP2: begin
                alu_a   = EW'(r_fgot);
                alu_b   = EW'(r_res);
                alu_sub = 1'b0;
            end
            S_PHASE_END: begin
                alu_a   = EW'(r_total);
                alu_b   = EW'(r_res);
                alu_sub = 1'b0;
            end
            default: begin
            end
        endcase
    end

    dmf_arc_store #(
        .MAX_NODES (MAX_NODES),
        .MAX_ARCS  (MAX_ARCS),
        .CAP_BITS  (CAP_BITS)
    ) u_arcs (
        .i_clk       (i_clk),
        .i_ctl       (arc_ctl),
        .i_arc_addr  (arc_addr),
        .i_pair_addr (pair_addr),
        .i_odd       (arc_odd),
        .i_target    (arc_wt),
        .i_next      (arc_wn),
        .i_cap       (CAP_BITS'(r_cap)),
        .i_flow      (arc_wflow),
        .o_target    (arc_target),
        .o_next      (arc_next),
        .o_room      (arc_room),
        .o_flow      (arc_flow)
    );

    // adjacency heads
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        r_head_rd    <= r_head_mem[head_ra];
        r_head_rd_ok <= r_head_ok[head_ra];
    end

    // node levels and labelling queue
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_wa] <= lvl_wd;
        end
        r_lvl_rd <= r_lvl_mem[lvl_ra];
        if (q_we) begin
            r_q_mem[q_wa] <= q_wd;
        end
        r_q_rd <= r_q_mem[q_ra];
    end

    // search stack of parked parent frames
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= {r_fn, r_fa, r_fin, r_fneed, r_fgot, r_flv};
        end
        r_stk_rd <= r_stk_mem[stk_ra];
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_arc_cnt    <= '0;
            r_head_ok    <= '0;
            r_lvl_ok     <= '0;
            r_node_count <= dmf_pkg::CFG_W'(RST_NC);
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_data == '0) begin
                    r_node_count <= dmf_pkg::CFG_W'(1);
                end else if (32'(i_cfg_data) > MAX_NODES) begin
                    r_node_count <= dmf_pkg::CFG_W'(MAX_NODES);
                end else begin
                    r_node_count <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_a   <= i_node_a;
                        r_b   <= i_node_b;
                        r_cap <= i_capacity;
                        r_out_flow   <= '0;
                        r_out_status <= in_status;
                        case (i_kind)
                            dmf_pkg::KIND_CLEAR: begin
                                r_head_ok <= '0;
                                r_arc_cnt <= '0;
                            end
                            dmf_pkg::KIND_ADD: begin
                                if (add_go) begin
                                    r_state <= S_ADD0;
                                end
                            end
                            dmf_pkg::KIND_COMPUTE: begin
                                if (cmp_go) begin
                                    r_idx   <= '0;
                                    r_total <= '0;
                                    r_state <= S_CLR;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ADD0: r_state <= S_ADD1;
                S_ADD1: begin
                    r_head_ok[node_a] <= 1'b1;
                    r_state <= S_ADD2;
                end
                S_ADD2: r_state <= S_ADD3;
                S_ADD3: begin
                    r_head_ok[node_b] <= 1'b1;
                    r_arc_cnt   <= r_arc_cnt + AW'(2);
                    r_state     <= S_IDLE;
                end
                // zero one pair flow per cycle
                S_CLR: begin
                    if (r_idx == (r_arc_cnt >> 1)) begin
                        r_state <= S_LVL_INIT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_LVL_INIT: begin
                    r_lvl_ok <= MAX_NODES'(1) << node_a;
                    r_rd    <= '0;
                    r_wr    <= SPW'(1);
                    r_state <= S_BFS_POP;
                end
                // labelling: take the next queued node or finish the phase
                S_BFS_POP: begin
                    if (r_rd == r_wr) begin
                        if (r_lvl_ok[node_b]) begin
                            r_state <= S_DFS_INIT;
                        end else begin
                            r_out_flow  <= r_total;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_rd    <= r_rd + 1'b1;
                        r_state <= S_BFS_HEAD;
                    end
                end
                S_BFS_HEAD: begin
                    r_x_lv  <= r_q_rd[QW-1:NW];
                    r_state <= S_BFS_HEADW;
                end
                S_BFS_HEADW: begin
                    r_arc   <= head_next;
                    r_state <= S_BFS_ARC;
                end
                S_BFS_ARC: begin
                    r_state <= (r_arc == NO_ARC) ? S_BFS_POP : S_BFS_EVAL;
                end
                S_BFS_EVAL: begin
                    if (bfs_label) begin
                        r_lvl_ok[arc_target] <= 1'b1;
                        if (32'(r_wr) < MAX_NODES) begin
                            r_wr <= r_wr + 1'b1;
                        end
                    end
                    r_arc   <= arc_next;
                    r_state <= S_BFS_ARC;
                end
                // search: open the frame of the source
                S_DFS_INIT: begin
                    r_fn    <= node_a;
                    r_fin   <= NO_ARC;
                    r_fneed <= dmf_pkg::NEED_TOP;
                    r_fgot  <= '0;
                    r_flv   <= '0;
                    r_sp    <= '0;
                    r_state <= S_DFS_HEAD;
                end
                S_DFS_HEAD: begin
                    r_fa    <= head_next;
                    r_state <= S_DFS_STEP;
                end
                S_DFS_STEP: begin
                    if (!dfs_hit && dfs_adv) begin
                        r_state <= S_DFS_ARC;
                    end else begin
                        if (dfs_hit) begin
                            r_res <= r_fneed;
                        end else begin
                            r_res <= r_fgot;
                            if (r_fgot == '0) begin
                                r_lvl_ok[r_fn] <= 1'b0;
                            end
                        end
                        r_state <= (r_sp == '0) ? S_PHASE_END : S_DFS_POP1;
                    end
                end
                S_DFS_ARC: begin
                    r_y     <= arc_target;
                    r_room  <= arc_room;
                    r_cur   <= r_fa;
                    r_fa    <= arc_next;
                    r_left  <= dmf_pkg::NEED_W'(alu_y);
                    r_state <= S_DFS_LVL;
                end
                // park the frame and descend along the arc if it qualifies, else try the next arc
                S_DFS_LVL: begin
                    if (dfs_push) begin
                        r_sp    <= r_sp + 1'b1;
                        r_fn    <= r_y;
                        r_fin   <= r_cur;
                        r_fneed <= (room_ext < r_left) ? room_ext : r_left;
                        r_fgot  <= '0;
                        r_flv   <= r_flv + 1'b1;
                        r_state <= S_DFS_HEAD;
                    end else begin
                        r_state <= S_DFS_STEP;
                    end
                end
                // return to the parent frame
                S_DFS_POP1: begin
                    r_sp <= r_sp - 1'b1;
                    {r_fn, r_fa, r_fin, r_fneed, r_fgot, r_flv} <= r_stk_rd;
                    r_state <= S_DFS_POP2;
                end
                S_DFS_POP2: begin
                    r_fgot  <= dmf_pkg::NEED_W'(alu_y);
                    r_state <= S_DFS_STEP;
                end
                S_PHASE_END: begin
                    if (alu_y > EW'(dmf_pkg::OUT_MAX)) begin
                        r_total <= dmf_pkg::OUT_MAX;
                    end else begin
                        r_total <= dmf_pkg::OUT_W'(alu_y);
                    end
                    r_state <= S_LVL_INIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = !busy;
    assign o_valid      = r_out_valid;
    assign o_total_flow = r_out_flow;
    assign o_status     = r_out_status;

    // the top frame's level always equals its stack depth
    a_lvl_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DFS_STEP) |-> (r_flv == NW'(r_sp)))
        else $error("search frame level differs from stack depth");

    // a frame never collects more than it asked for
    a_got_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DFS_STEP) |-> (r_fgot <= r_fneed))
        else $error("search frame got exceeds need");

    // arcs are stored in pairs within the table
    a_arc_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_arc_cnt[0] && (32'(r_arc_cnt) <= MAX_ARCS)))
        else $error("arc count odd or beyond table");

    // the labelling queue never reads past its fill point
    a_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BFS_POP) |-> (r_rd <= r_wr))
        else $error("labelling queue read beyond write");

    // an add always steps from S_ADD1 to S_ADD2
    a_add_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD1) |=> (r_state == S_ADD2))
        else $error("add sequence broken");

endmodule

/* rtl/dmf_arc_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_arc_store: arc tables of the flow engine
// Per-arc target and next pointer, per-pair capacity and forward flow, and
// the residual room of the arc that was read.
// ----------------------------------------------------------------------------
module dmf_arc_store #(
    parameter int MAX_NODES = dmf_pkg::DEF_MAX_NODES,
    parameter int MAX_ARCS  = dmf_pkg::DEF_MAX_ARCS,
    parameter int CAP_BITS  = dmf_pkg::DEF_CAP_BITS
) (
    input  logic                                 i_clk,
    input  dmf_pkg::t_arc_ctl                    i_ctl,
    input  logic [$clog2(MAX_ARCS)-1:0]          i_arc_addr,
    input  logic [((MAX_ARCS > 2) ? $clog2((MAX_ARCS+1)/2) : 1)-1:0] i_pair_addr,
    input  logic                                 i_odd,
    input  logic [$clog2(MAX_NODES)-1:0]         i_target,
    input  logic [$clog2(MAX_ARCS+1)-1:0]        i_next,
    input  logic [CAP_BITS-1:0]                  i_cap,
    input  logic [CAP_BITS-1:0]                  i_flow,
    output logic [$clog2(MAX_NODES)-1:0]         o_target,
    output logic [$clog2(MAX_ARCS+1)-1:0]        o_next,
    output logic [CAP_BITS-1:0]                  o_room,
    output logic [CAP_BITS-1:0]                  o_flow
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int AW = $clog2(MAX_ARCS + 1);
    localparam int PD = (MAX_ARCS + 1) / 2;

    logic [NW-1:0]       r_target_mem [MAX_ARCS];
    logic [AW-1:0]       r_next_mem   [MAX_ARCS];
    logic [CAP_BITS-1:0] r_cap_mem    [PD];
    logic [CAP_BITS-1:0] r_flow_mem   [PD];

    logic [CAP_BITS-1:0] r_cap_rd;
    logic                r_odd;

    // per-arc tables
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_arc) begin
            r_target_mem[i_arc_addr] <= i_target;
            r_next_mem[i_arc_addr]   <= i_next;
        end
        o_target <= r_target_mem[i_arc_addr];
        o_next   <= r_next_mem[i_arc_addr];
    end

    // per-pair capacity and forward flow
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_cap) begin
            r_cap_mem[i_pair_addr] <= i_cap;
        end
        if (i_ctl.wr_flow) begin
            r_flow_mem[i_pair_addr] <= i_flow;
        end
        r_cap_rd <= r_cap_mem[i_pair_addr];
        o_flow   <= r_flow_mem[i_pair_addr];
        r_odd    <= i_odd;
    end

    // forward arc: capacity less flow; reverse arc: the forward flow
    assign o_room = r_odd ? o_flow : (r_cap_rd - o_flow);

endmodule
